// ===== sv/fsr_pkg.sv =====
// Shared types and constants of the start-byte frame receiver.
package fsr_pkg;

    typedef logic [7:0] t_byte;
    typedef logic [4:0] t_pos;

    localparam t_byte START_BYTE  = 8'hFF;
    localparam int    HEADER_MIN  = 5;
    localparam int    SHORT_FRAME = 6;
    // Width that holds the header size plus any length field value.
    localparam int    TGT_W       = 9;

endpackage

// ===== sv/fsr_store.sv =====
// Frame byte store: one write port and one registered read port.
module fsr_store
    import fsr_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_byte         i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_byte         o_rd_data
);

    t_byte r_mem [DEPTH];
    t_byte r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // The read register holds its value until the next read request.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/start_length_frame_receiver.sv =====
// Frame receiver: bytes are taken one per cycle while a frame is being gathered;
// bytes outside a frame are dropped unless they are the start byte 0xFF. When a
// frame completes (at 6 bytes for a length field of 0, otherwise at 5 plus the
// length field, and at most MAX_FRAME_LEN - 1 bytes) the frame is read back out
// of the byte store one byte at a time, each through a read request state and a
// load state, since the store has a registered read port; a load waits on any
// stall from the result side. No received byte is taken during readout.
module start_length_frame_receiver
    import fsr_pkg::*;
#(
    parameter int MAX_FRAME_LEN = 32
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_byte i_rx_byte,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    output t_byte o_frame_byte,
    output t_pos  o_byte_position,
    output t_pos  o_frame_length,
    output logic  o_last_byte
);

    localparam int CW = $clog2(MAX_FRAME_LEN);
    localparam logic [CW-1:0] CUT_LEN = CW'(MAX_FRAME_LEN - 1);
    localparam logic [CW-1:0] LEN_IDX = CW'(2);

    localparam logic [1:0] ST_RECV    = 2'd0;
    localparam logic [1:0] ST_RD_REQ  = 2'd1;
    localparam logic [1:0] ST_RD_LOAD = 2'd2;

    logic [1:0]    r_state, n_state;
    logic          r_open, n_open;
    logic [CW-1:0] r_count, n_count;
    t_byte         r_len_field, n_len_field;
    logic [CW-1:0] r_frame_len, n_frame_len;
    logic [CW-1:0] r_rd_idx, n_rd_idx;
    logic          r_out_valid, n_out_valid;
    t_byte         r_frame_byte;
    logic [CW-1:0] r_out_pos;
    logic [CW-1:0] r_out_len;
    logic          r_out_last;

    logic              in_fire;
    logic              take_byte;
    logic [CW-1:0]     cnt_inc;
    t_byte             len_now;
    logic [TGT_W-1:0]  target;
    logic              done;
    logic              slot_free;
    logic              load_out;
    logic              rd_last;
    t_byte             rd_data;

    assign o_in_ready = (r_state == ST_RECV);
    assign in_fire    = i_in_valid && o_in_ready;
    assign take_byte  = in_fire && (r_open || (i_rx_byte == START_BYTE));
    assign cnt_inc    = r_count + CW'(1);

    // The length field is the byte arriving now when that byte is at index 2 of the frame.
    assign len_now = (r_count == LEN_IDX) ? i_rx_byte : r_len_field;
    assign target  = (len_now == '0) ? TGT_W'(SHORT_FRAME)
                                     : TGT_W'(HEADER_MIN) + TGT_W'(len_now);
    assign done    = (TGT_W'(cnt_inc) > TGT_W'(HEADER_MIN))
                     && ((TGT_W'(cnt_inc) == target) || (cnt_inc >= CUT_LEN));

    assign slot_free = !r_out_valid || i_out_ready;
    assign load_out  = (r_state == ST_RD_LOAD) && slot_free;
    assign rd_last   = (r_rd_idx + CW'(1)) == r_frame_len;

    fsr_store #(
        .DEPTH (MAX_FRAME_LEN),
        .AW    (CW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (take_byte),
        .i_wr_addr (r_count),
        .i_wr_data (i_rx_byte),
        .i_rd_en   (r_state == ST_RD_REQ),
        .i_rd_addr (r_rd_idx),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state     = r_state;
        n_open      = r_open;
        n_count     = r_count;
        n_len_field = r_len_field;
        n_frame_len = r_frame_len;
        n_rd_idx    = r_rd_idx;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            ST_RECV: begin
                if (take_byte) begin
                    n_open  = 1'b1;
                    n_count = cnt_inc;
                    if (r_count == LEN_IDX) begin
                        n_len_field = i_rx_byte;
                    end
                    if (done) begin
                        n_open      = 1'b0;
                        n_count     = '0;
                        n_frame_len = cnt_inc;
                        n_rd_idx    = '0;
                        n_state     = ST_RD_REQ;
                    end
                end
            end
            ST_RD_REQ: begin
                n_state = ST_RD_LOAD;
            end
            ST_RD_LOAD: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    if (rd_last) begin
                        n_state = ST_RECV;
                    end else begin
                        n_rd_idx = r_rd_idx + CW'(1);
                        n_state  = ST_RD_REQ;
                    end
                end
            end
            default: begin
                n_state = ST_RECV;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RECV;
            r_open      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_open      <= n_open;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // The length travels with each result, so a frame completing behind a
    // stalled last byte cannot alter it.
    always_ff @(posedge i_clk) begin
        r_len_field <= n_len_field;
        r_frame_len <= n_frame_len;
        r_rd_idx    <= n_rd_idx;
        if (load_out) begin
            r_frame_byte <= rd_data;
            r_out_pos    <= r_rd_idx;
            r_out_len    <= r_frame_len;
            r_out_last   <= rd_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_frame_byte    = r_frame_byte;
    assign o_byte_position = t_pos'(r_out_pos);
    assign o_frame_length  = t_pos'(r_out_len);
    assign o_last_byte     = r_out_last;

endmodule

// ===== sv/fsr_checker.sv =====
// Port-level checks of the frame receiver, bound to the top level.
module fsr_checker
    import fsr_pkg::*;
(
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  o_in_ready,
    input logic  o_out_valid,
    input logic  i_out_ready,
    input t_byte o_frame_byte,
    input t_pos  o_byte_position,
    input t_pos  o_frame_length,
    input logic  o_last_byte
);

    // A stalled result keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_frame_byte)
        && $stable(o_byte_position) && $stable(o_frame_length) && $stable(o_last_byte))
        else $error("result changed while stalled");

    // The last byte of a frame sits at position length minus one.
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last_byte |-> t_pos'(o_byte_position + 5'd1) == o_frame_length)
        else $error("last byte at wrong position");

    // Every frame opens with the start byte.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_byte_position == '0 |-> o_frame_byte == START_BYTE)
        else $error("frame does not open with start byte");

    // No received byte is taken while a frame is still being read out.
    a_no_rx_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last_byte |-> !o_in_ready)
        else $error("request taken during readout");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind start_length_frame_receiver fsr_checker u_fsr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_frame_byte    (o_frame_byte),
    .o_byte_position (o_byte_position),
    .o_frame_length  (o_frame_length),
    .o_last_byte     (o_last_byte)
);
